[sv/rtscan_pkg.sv]
// shared types, constants and helpers for the resonance transition scan
`timescale 1ns / 1ps
package rtscan_pkg;

  localparam int unsigned LevelsDefault = 8;
  localparam int unsigned DataW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InTdataW = 96;
  localparam int unsigned OutTdataW = 200;
  localparam int unsigned DivQuotW = 33;

  localparam logic [1:0] StatusTransition = 2'd0;
  localparam logic [1:0] StatusNone = 2'd1;
  localparam logic [1:0] StatusTooMany = 2'd2;

  localparam logic [CfgIdxW-1:0] RegDriveFrequency = 2'd0;
  localparam logic [CfgIdxW-1:0] RegPopThreshold = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSlopeMinimum = 2'd2;
  localparam logic [CfgIdxW-1:0] RegRecipMaximum = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD_M,
    S_RD_N,
    S_DIFF,
    S_TEST,
    S_DIV,
    S_MUL,
    S_SCALE,
    S_EMIT,
    S_NEXT,
    S_FINISH,
    S_FLAG
  } scan_state_e;

  typedef struct packed {
    logic        start;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DivQuotW-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  lower_index;
    logic [3:0]  upper_index;
    logic [31:0] transition_frequency;
    logic [31:0] detuning;
    logic [31:0] population_gap;
    logic [30:0] slope_gap;
    logic [30:0] slope_reciprocal;
    logic [31:0] field_detuning;
    logic        run_end;
  } scan_res_t;

  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v > 34'sh0_7FFF_FFFF) begin
      r = 32'h7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      r = 32'h8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic scan_res_t flag_res(input logic [1:0] st);
    scan_res_t r;
    r = '0;
    r.status = st;
    r.run_end = 1'b1;
    return r;
  endfunction

endpackage

[sv/rtscan_div.sv]
// restoring divider computing 2^32 over a 32 bit divisor, one quotient bit per cycle
`timescale 1ns / 1ps
module rtscan_div
  import rtscan_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [31:0]         rem_q, rem_d;
  logic [DivQuotW-1:0] quot_q, quot_d;
  logic [31:0]         dvs_q, dvs_d;
  logic [5:0]          cnt_q, cnt_d;
  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [32:0]         trial;
  logic                take;

  always_comb begin
    trial = {rem_q, (cnt_q == 6'd32)};
    take = trial >= {1'b0, dvs_q};
    rem_d = rem_q;
    quot_d = quot_q;
    dvs_d = dvs_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = '0;
      quot_d = '0;
      dvs_d = req_i.divisor;
      cnt_d = 6'd32;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = take ? 32'(trial - {1'b0, dvs_q}) : trial[31:0];
      quot_d = {quot_q[DivQuotW-2:0], take};
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quot_q <= quot_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

[sv/resonance_transition_scan.sv]
// top level: level store, pair sequencer and shared reciprocal divider
`timescale 1ns / 1ps
// Levels arrive one word per cycle while the block is idle; the word with tlast
// set closes the set and starts the scan, during which s_axis_tready is low.
// Each pair (lower m < upper n) is read, differenced and tested; a kept pair
// then takes its reciprocal from the shared one bit per cycle divider before
// the multiply, scale and emit steps. A kept result is held back one pair so
// that the last one can carry tlast; an empty scan gives one none word, an
// oversized set one error word.
module resonance_transition_scan
  import rtscan_pkg::*;
#(
  parameter int unsigned LEVELS = LevelsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // level_energy, level_population, level_slope
  input  logic [InTdataW-1:0]  s_axis_tdata,
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // lower_index, upper_index, transition_frequency, detuning, population_gap,
  // slope_gap, slope_reciprocal, field_detuning, zero fill
  output logic [OutTdataW-1:0] m_axis_tdata,
  // status
  output logic [1:0]           m_axis_tuser,
  output logic                 m_axis_tlast,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);

  localparam int unsigned IW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int unsigned CW = $clog2(LEVELS + 1);
  localparam logic [CW-1:0] LevelsC = CW'(LEVELS);

  scan_state_e state_q, state_d;

  logic [31:0] drive_q;
  logic [30:0] thr_q, smin_q, rmax_q;

  logic [95:0] mem_q [LEVELS];
  logic [95:0] rd_q, a_q;
  logic [IW-1:0] rd_addr;

  logic [CW-1:0] cnt_q, lvl_q, m_q, n_q;
  logic          ovf_q;

  logic signed [32:0] freq_q, pop_q;
  logic [31:0]        det_q, slope_q;
  logic signed [63:0] prod_q;
  logic [31:0]        field_q;
  logic [30:0]        recip_q;

  scan_res_t pend_q, out_q, new_res, last_res;
  logic      pend_vld_q, out_vld_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic in_acc, full, ovf_next, out_free, keep, push;
  logic [CW-1:0] cnt_next;
  logic signed [33:0] det_wide;
  logic signed [32:0] sd;
  logic [32:0] pop_mag;
  logic [62:0] rprod;
  logic [63:0] mag;
  logic [57:0] fm;
  logic [31:0] fm_clip;

  rtscan_div u_div (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign full = (cnt_q == LevelsC);
  assign ovf_next = ovf_q || full;
  assign cnt_next = full ? cnt_q : cnt_q + CW'(1);
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    pop_mag = pop_q[32] ? 33'(-pop_q) : 33'(pop_q);
    rprod = 63'(rmax_q) * 63'(slope_q);
    keep = (pop_mag >= {2'b0, thr_q}) && (slope_q != 32'd0) &&
           (slope_q >= {1'b0, smin_q}) && (rprod[62:32] != '0);
    mag = prod_q[63] ? 64'(-prod_q) : 64'(prod_q);
    fm = 58'(mag[63:16]) * 58'd1000 + 58'((26'(mag[15:0]) * 26'd1000) >> 16);
    fm_clip = (fm > 58'h0_8000_0000) ? 32'h8000_0000 : fm[31:0];
  end

  always_comb begin
    new_res = '0;
    new_res.status = StatusTransition;
    new_res.lower_index = 4'(m_q);
    new_res.upper_index = 4'(n_q);
    new_res.transition_frequency = sat32(34'(freq_q));
    new_res.detuning = det_q;
    new_res.population_gap = sat32(34'(pop_q));
    new_res.slope_gap = slope_q[31] ? 31'h7FFF_FFFF : slope_q[30:0];
    new_res.slope_reciprocal = recip_q;
    new_res.field_detuning = field_q;
    new_res.run_end = 1'b0;
    last_res = pend_q;
    last_res.run_end = 1'b1;
  end

  always_comb begin
    state_d = state_q;
    s_axis_tready = 1'b0;
    div_req.start = 1'b0;
    div_req.divisor = slope_q;
    push = 1'b0;
    rd_addr = m_q[IW-1:0];
    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_acc && s_axis_tlast) begin
          if (ovf_next) begin
            state_d = S_FLAG;
          end else if (cnt_next < CW'(2)) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_RD_M;
          end
        end
      end
      S_RD_M: state_d = S_RD_N;
      S_RD_N: begin
        rd_addr = n_q[IW-1:0];
        state_d = S_DIFF;
      end
      S_DIFF: state_d = S_TEST;
      S_TEST: begin
        if (keep) begin
          div_req.start = 1'b1;
          state_d = S_DIV;
        end else begin
          state_d = S_NEXT;
        end
      end
      S_DIV: if (div_rsp.done) state_d = S_MUL;
      S_MUL: state_d = S_SCALE;
      S_SCALE: state_d = S_EMIT;
      S_EMIT: begin
        if (!pend_vld_q) begin
          state_d = S_NEXT;
        end else if (out_free) begin
          push = 1'b1;
          state_d = S_NEXT;
        end
      end
      S_NEXT: begin
        if (n_q + CW'(1) < lvl_q || m_q + CW'(2) < lvl_q) begin
          state_d = S_RD_M;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_FINISH, S_FLAG: begin
        if (out_free) begin
          push = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      drive_q <= '0;
      thr_q <= '0;
      smin_q <= '0;
      rmax_q <= 31'h7FFF_FFFF;
      cnt_q <= '0;
      ovf_q <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegDriveFrequency: drive_q <= cfg_data_i;
          RegPopThreshold:   thr_q <= cfg_data_i[30:0];
          RegSlopeMinimum:   smin_q <= cfg_data_i[30:0];
          RegRecipMaximum:   rmax_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (s_axis_tlast) begin
          cnt_q <= '0;
          ovf_q <= 1'b0;
        end else begin
          cnt_q <= cnt_next;
          ovf_q <= ovf_next;
        end
      end
      if (push) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (state_q == S_EMIT && state_d == S_NEXT) begin
        pend_vld_q <= 1'b1;
      end else if (state_q == S_FINISH && push) begin
        pend_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && !full) begin
      mem_q[cnt_q[IW-1:0]] <= s_axis_tdata;
    end
    rd_q <= mem_q[rd_addr];
    if (in_acc && s_axis_tlast) begin
      lvl_q <= cnt_next;
      m_q <= '0;
      n_q <= CW'(1);
    end
    if (state_q == S_NEXT) begin
      if (n_q + CW'(1) < lvl_q) begin
        n_q <= n_q + CW'(1);
      end else begin
        m_q <= m_q + CW'(1);
        n_q <= m_q + CW'(2);
      end
    end
    if (state_q == S_RD_N) begin
      a_q <= rd_q;
    end
    if (state_q == S_DIFF) begin
      freq_q <= $signed({rd_q[31], rd_q[31:0]}) - $signed({a_q[31], a_q[31:0]});
      pop_q <= $signed({a_q[63], a_q[63:32]}) - $signed({rd_q[63], rd_q[63:32]});
      slope_q <= sd[32] ? 32'(-sd) : sd[31:0];
      det_q <= sat32(det_wide);
    end
    if (div_rsp.done) begin
      recip_q <= div_rsp.quot[30:0];
    end
    if (state_q == S_MUL) begin
      prod_q <= $signed(det_q) * $signed({1'b0, recip_q});
    end
    if (state_q == S_SCALE) begin
      if (prod_q[63]) begin
        field_q <= 32'(-fm_clip);
      end else begin
        field_q <= fm_clip[31] ? 32'h7FFF_FFFF : fm_clip;
      end
    end
    if (state_q == S_EMIT && state_d == S_NEXT) begin
      pend_q <= new_res;
    end
    if (push) begin
      case (state_q)
        S_EMIT:   out_q <= pend_q;
        S_FLAG:   out_q <= flag_res(StatusTooMany);
        default: begin
          if (pend_vld_q) begin
            out_q <= last_res;
          end else begin
            out_q <= flag_res(StatusNone);
          end
        end
      endcase
    end
  end

  always_comb begin
    sd = $signed({a_q[95], a_q[95:64]}) - $signed({rd_q[95], rd_q[95:64]});
    det_wide = $signed({rd_q[31], rd_q[31], rd_q[31:0]}) -
               $signed({a_q[31], a_q[31], a_q[31:0]}) -
               $signed({drive_q[31], drive_q[31], drive_q});
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser = out_q.status;
  assign m_axis_tlast = out_q.run_end;
  assign m_axis_tdata = {2'b00, out_q.field_detuning, out_q.slope_reciprocal,
                         out_q.slope_gap, out_q.population_gap, out_q.detuning,
                         out_q.transition_frequency, out_q.upper_index,
                         out_q.lower_index};

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !pend_vld_q) else $error("held result left after scan");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == S_DIV) else $error("divider finished outside divide");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= LevelsC) else $error("level count past store depth");

  a_recip_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_MUL |-> recip_q <= rmax_q) else $error("kept reciprocal above maximum");

endmodule

[sim/tb_top.sv]
// testbench for the resonance transition scan: level sets, pair results and register settings
`timescale 1ns / 1ps
module tb_top;
  import rtscan_pkg::*;

  localparam int unsigned NumLevels = 8;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [31:0] energy;
    logic [31:0] population;
    logic [31:0] slope;
    logic        last;
  } level_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i = '0;
  logic [31:0]          cfg_data_i = '0;

  resonance_transition_scan #(.LEVELS(NumLevels)) u_top (.*);

  always #1 clk_i = ~clk_i;

  // predictor state
  logic signed [31:0] lvl_energy [NumLevels];
  logic signed [31:0] lvl_pop [NumLevels];
  logic signed [31:0] lvl_slope [NumLevels];
  int unsigned        lvl_count;
  bit                 lvl_overflow;
  logic signed [31:0] drive_freq;
  logic [30:0]        pop_threshold, slope_min, recip_max;

  scan_res_t pending_results[$];
  int        error_count;
  int        idle_cycles;
  int        rx_gap;
  bit        rx_idle_en, tx_idle_en, rx_hold;

  function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic predict_level(input level_t lv);
    logic signed [63:0] pop, sdiff, freq, det, prod;
    logic [63:0] slope, recip, mag, fm;
    scan_res_t r;
    int cnt;
    if (lvl_count < NumLevels) begin
      lvl_energy[lvl_count] = lv.energy;
      lvl_pop[lvl_count] = lv.population;
      lvl_slope[lvl_count] = lv.slope;
      lvl_count++;
    end else lvl_overflow = 1'b1;
    if (!lv.last) return;
    cnt = 0;
    if (lvl_overflow) begin
      r = '0; r.status = StatusTooMany; r.run_end = 1'b1;
      pending_results.insert(pending_results.size(), r);
    end else begin
      for (int m = 0; m < lvl_count; m++) begin
        for (int n = m + 1; n < lvl_count; n++) begin
          pop = 64'(lvl_pop[m]) - 64'(lvl_pop[n]);
          sdiff = 64'(lvl_slope[n]) - 64'(lvl_slope[m]);
          slope = sdiff < 0 ? -sdiff : sdiff;
          if ((pop < 0 ? -pop : pop) < 64'(pop_threshold)) continue;
          if (slope == 0 || slope < 64'(slope_min)) continue;
          if (64'(recip_max) * slope < 64'h1_0000_0000) continue;
          recip = 64'h1_0000_0000 / slope;
          freq = 64'(lvl_energy[n]) - 64'(lvl_energy[m]);
          det = clamp32(freq - 64'(drive_freq));
          prod = det * $signed(recip);
          mag = prod < 0 ? -prod : prod;
          fm = (mag >> 16) * 1000 + (((mag & 64'hFFFF) * 1000) >> 16);
          if (fm > 64'h8000_0000) fm = 64'h8000_0000;
          r = '0;
          r.status = StatusTransition;
          r.lower_index = 4'(m);
          r.upper_index = 4'(n);
          r.transition_frequency = 32'(clamp32(freq));
          r.detuning = 32'(det);
          r.population_gap = 32'(clamp32(pop));
          r.slope_gap = slope > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : 31'(slope);
          r.slope_reciprocal = 31'(recip);
          r.field_detuning = prod < 0 ? 32'(-$signed(fm)) : 32'(clamp32($signed(fm)));
          pending_results.insert(pending_results.size(), r);
          cnt++;
        end
      end
      if (cnt == 0) begin
        r = '0; r.status = StatusNone; r.run_end = 1'b1;
        pending_results.insert(pending_results.size(), r);
      end else pending_results[$].run_end = 1'b1;
    end
    lvl_count = 0;
    lvl_overflow = 1'b0;
  endtask

  task automatic send_level(input level_t lv);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {lv.slope, lv.population, lv.energy};
    s_axis_tlast <= lv.last;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_level(lv);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (1300) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegDriveFrequency: drive_freq = val;
      RegPopThreshold: pop_threshold = val[30:0];
      RegSlopeMinimum: slope_min = val[30:0];
      default: recip_max = val[30:0];
    endcase
  endtask

  function automatic logic [31:0] rand_q(input int mode);
    case (mode)
      0: return $urandom();
      1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  task automatic send_set(input int unsigned size, input int mode);
    level_t lv;
    for (int i = 0; i < size; i++) begin
      lv.energy = rand_q(mode);
      lv.population = rand_q(mode);
      lv.slope = rand_q($urandom_range(0, 4) == 0 ? 0 : mode);
      lv.last = (i == size - 1);
      send_level(lv);
    end
  endtask

  task automatic test_directed();
    level_t lv;
    lv = '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0}; send_level(lv);
    lv = '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0}; send_level(lv);
    lv = '{32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0}; send_level(lv);
    lv = '{32'h0, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0}; send_level(lv);
    lv = '{32'hFFFF_0000, 32'h0000_8000, 32'h0000_0001, 1'b1}; send_level(lv);
    // single level gives none
    lv = '{32'h1234_5678, 32'h0, 32'h0, 1'b1}; send_level(lv);
    // equal slopes only, no kept pair
    lv = '{32'h1, 32'h2, 32'h5, 1'b0}; send_level(lv);
    lv = '{32'h3, 32'h4, 32'h5, 1'b1}; send_level(lv);
    // full store and overflow, final item dropped too
    send_set(NumLevels, 2);
    send_set(NumLevels + 2, 1);
  endtask

  task automatic test_config();
    write_reg(RegDriveFrequency, 32'h8000_0000);
    write_reg(RegPopThreshold, 32'h7FFF_FFFF);
    send_set(4, 0);
    write_reg(RegPopThreshold, 32'h0001_0000);
    write_reg(RegSlopeMinimum, 32'h7FFF_FFFF);
    send_set(4, 3);
    write_reg(RegSlopeMinimum, 32'h0000_8000);
    write_reg(RegRecipMaximum, 32'h1);
    send_set(4, 2);
    write_reg(RegRecipMaximum, 32'h0004_0000);
    write_reg(RegDriveFrequency, 32'h7FFF_FFFF);
    send_set(5, 1);
    write_reg(RegDriveFrequency, 32'h0003_0000);
    write_reg(RegPopThreshold, 32'h0);
    write_reg(RegSlopeMinimum, 32'h0);
    write_reg(RegRecipMaximum, 32'h7FFF_FFFF);
  endtask

  task automatic test_random(input int unsigned target);
    int unsigned sent;
    int unsigned size;
    level_t lv;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        lv = '{$urandom(), $urandom(), $urandom(), 1'($urandom_range(0, 1))};
        send_level(lv);
        sent++;
      end else begin
        size = $urandom_range(0, 11) == 0 ? $urandom_range(9, 11) : $urandom_range(2, 5);
        send_set(size, $urandom_range(0, 3));
        sent += size;
      end
    end
  endtask

  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        send_set(6, 1);
        send_set(3, 2);
      end
      begin
        repeat (3000) @(posedge clk_i);
        rx_hold = 1'b0;
      end
    join
  endtask

  // result checker
  always @(posedge clk_i) begin
    scan_res_t got, exp_r;
    if (m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tuser, m_axis_tdata[3:0], m_axis_tdata[7:4], m_axis_tdata[39:8],
              m_axis_tdata[71:40], m_axis_tdata[103:72], m_axis_tdata[134:104],
              m_axis_tdata[165:135], m_axis_tdata[197:166], m_axis_tlast};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
          error_count++;
        end
      end
    end
  end

  // receiver idling
  always @(posedge clk_i) begin
    if (rx_hold) m_axis_tready <= 1'b0;
    else if (rx_gap != 0) begin
      m_axis_tready <= 1'b0;
      rx_gap <= rx_gap - 1;
    end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      rx_gap <= $urandom_range(0, 9);
    end else m_axis_tready <= 1'b1;
  end

  // stall watchdog
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    idle_cycles = 0;
    rx_gap = 0;
    lvl_count = 0;
    lvl_overflow = 1'b0;
    drive_freq = '0;
    pop_threshold = '0;
    slope_min = '0;
    recip_max = 31'h7FFF_FFFF;
    rx_idle_en = 1'b1;
    tx_idle_en = 1'b1;
    rx_hold = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_config();
    test_backpressure();
    test_random(180);
    rx_idle_en = 1'b0;
    tx_idle_en = 1'b0;
    test_random(40);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (1300) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/rtscan_pkg.sv
sv/rtscan_div.sv
sv/resonance_transition_scan.sv
sim/tb_top.sv
